// File: rtl/stt_pkg.sv
// shared types, character codes and token helpers for the style text tokenizer
// used by stt_lexer, stt_result_buf and style_text_tokenizer_unit
package stt_pkg;

    localparam int unsigned MAX_TEXT_BYTES_DEF = 65536;
    localparam int unsigned RESULTS_PER_BYTE   = 3;

    typedef enum logic [6:0] {
        MODE_IDLE   = 7'b0000001,
        MODE_IDENT  = 7'b0000010,
        MODE_NUMBER = 7'b0000100,
        MODE_MINUS  = 7'b0001000,
        MODE_HASH   = 7'b0010000,
        MODE_STRING = 7'b0100000,
        MODE_ESCAPE = 7'b1000000
    } t_mode;

    typedef enum logic [3:0] {
        KIND_END       = 4'd0,
        KIND_IDENT     = 4'd1,
        KIND_NUMBER    = 4'd2,
        KIND_HASH      = 4'd3,
        KIND_STRING    = 4'd4,
        KIND_COLON     = 4'd5,
        KIND_SEMICOLON = 4'd6,
        KIND_LBRACE    = 4'd7,
        KIND_RBRACE    = 4'd8,
        KIND_COMMA     = 4'd9,
        KIND_INVALID   = 4'd10
    } t_kind;

    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_SEMICOLON = 8'h3B;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_UNDER     = 8'h5F;
    localparam logic [7:0] CH_BSLASH    = 8'h5C;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;

    localparam logic [15:0] SIZE_MAX  = 16'hFFFF;
    localparam logic [31:0] MAG_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] COLOR_WHITE = 32'hFFFF_FFFF;
    localparam logic [7:0]  ALPHA_FULL  = 8'hFF;
    localparam logic [3:0]  HEX_PACK_MAX  = 4'd8;
    localparam logic [3:0]  HEX_COUNT_MAX = 4'd15;
    localparam logic [3:0]  HEX_SHORT     = 4'd3;
    localparam logic [3:0]  HEX_RGB       = 4'd6;

    typedef struct packed {
        t_kind              kind;
        logic [15:0]        offset;
        logic [15:0]        size;
        logic signed [31:0] value;
        logic               sat;
        logic [31:0]        color;
    } t_token;

    typedef struct packed {
        logic   valid;
        t_token tok;
    } t_cand;

    // all results of one word, in delivery order
    typedef struct packed {
        logic [1:0]                        count;
        t_token [RESULTS_PER_BYTE-1:0]     tok;
    } t_bundle;

    function automatic logic is_digit(input logic [7:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return b inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b inside {8'h20, [8'h09:8'h0D]};
    endfunction

    function automatic logic is_ident_char(input logic [7:0] b);
        return is_alpha(b) || is_digit(b) || b == CH_UNDER || b == CH_MINUS;
    endfunction

    // {ok, nibble}; 'x' counts as a zero nibble
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (is_digit(b)) begin
            r = {1'b1, b[3:0]};
        end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            r = {1'b1, b[3:0] + 4'd9};
        end else if (b == CH_LOWER_X) begin
            r = 5'b10000;
        end
        return r;
    endfunction

    // token for whatever is open in the given lexer state
    function automatic t_cand make_pending(
        input t_mode       mode,
        input logic [15:0] start,
        input logic [15:0] len,
        input logic [31:0] mag,
        input logic        neg,
        input logic        ovf,
        input logic [31:0] hacc,
        input logic [3:0]  hcnt
    );
        t_cand c;
        c.valid      = 1'b1;
        c.tok.kind   = KIND_IDENT;
        c.tok.offset = start;
        c.tok.size   = len;
        c.tok.value  = '0;
        c.tok.sat    = 1'b0;
        c.tok.color  = '0;
        case (mode)
            MODE_IDENT, MODE_MINUS: begin
                c.tok.kind = KIND_IDENT;
            end
            MODE_NUMBER: begin
                c.tok.kind  = KIND_NUMBER;
                c.tok.value = neg ? (32'd0 - mag) : mag;
                c.tok.sat   = ovf;
            end
            MODE_HASH: begin
                c.tok.kind = KIND_HASH;
                if (hcnt < HEX_SHORT) begin
                    c.tok.color = COLOR_WHITE;
                end else if (hcnt == HEX_RGB) begin
                    c.tok.color = {hacc[23:0], ALPHA_FULL};
                end else begin
                    c.tok.color = hacc;
                end
            end
            MODE_STRING, MODE_ESCAPE: begin
                c.tok.kind = KIND_STRING;
            end
            default: begin
                c.valid = 1'b0;
            end
        endcase
        return c;
    endfunction

endpackage

// File: rtl/stt_lexer.sv
// lexer state registers and the single-pass next-state and token logic
// depends on stt_pkg
module stt_lexer
    import stt_pkg::*;
#(
    parameter int unsigned MAX_TEXT_BYTES = MAX_TEXT_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_text_byte,
    input  logic        i_final_byte,
    output t_bundle     o_bundle
);

    localparam int POS_W  = $clog2(MAX_TEXT_BYTES);
    localparam int WIDE_W = (POS_W + 1 > 16) ? POS_W + 1 : 16;

    t_mode             r_mode, n_mode;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [15:0]       r_start, n_start;
    logic [15:0]       r_len, n_len;
    logic [31:0]       r_mag, n_mag;
    logic              r_neg, n_neg;
    logic              r_ovf, n_ovf;
    logic              r_single, n_single;
    logic [31:0]       r_hacc, n_hacc;
    logic [3:0]        r_hcnt, n_hcnt;

    logic [WIDE_W-1:0] pos_ext;
    logic [WIDE_W-1:0] pos_inc;
    logic [15:0]       len_inc;
    logic [4:0]        hex;
    logic              done;
    logic              brk;
    t_cand             cand [4];
    logic [1:0]        idx;

    // {overflow, magnitude} after appending one decimal digit
    function automatic logic [32:0] add_digit(input logic [31:0] mag, input logic [7:0] b);
        logic [34:0] m;
        m = ({3'b0, mag} << 3) + ({3'b0, mag} << 1) + 35'(b - CH_ZERO);
        if (m > 35'(MAG_MAX)) begin
            return {1'b1, MAG_MAX};
        end
        return {1'b0, m[31:0]};
    endfunction

    assign pos_ext = WIDE_W'(r_pos);
    assign pos_inc = pos_ext + WIDE_W'(1);
    assign len_inc = (r_len != SIZE_MAX) ? r_len + 16'd1 : r_len;
    assign hex     = hex_nibble(i_text_byte);

    always_comb begin
        logic [32:0] dig;
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_start  = r_start;
        n_len    = r_len;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_ovf    = r_ovf;
        n_single = r_single;
        n_hacc   = r_hacc;
        n_hcnt   = r_hcnt;
        done     = 1'b0;
        brk      = 1'b0;
        dig      = add_digit(r_mag, i_text_byte);
        for (int k = 0; k < 4; k++) begin
            cand[k] = '0;
        end

        // continue or close the open token
        case (r_mode)
            MODE_IDENT: begin
                if (is_ident_char(i_text_byte)) begin
                    n_len = len_inc;
                    done  = 1'b1;
                end else begin
                    brk = 1'b1;
                end
            end
            MODE_NUMBER: begin
                if (is_digit(i_text_byte)) begin
                    n_mag = dig[31:0];
                    n_ovf = r_ovf | dig[32];
                    n_len = len_inc;
                    done  = 1'b1;
                end else begin
                    brk = 1'b1;
                end
            end
            MODE_MINUS: begin
                if (is_digit(i_text_byte)) begin
                    n_mode = MODE_NUMBER;
                    n_neg  = 1'b1;
                    n_mag  = dig[31:0];
                    n_ovf  = r_ovf | dig[32];
                    n_len  = len_inc;
                    done   = 1'b1;
                end else if (is_ident_char(i_text_byte)) begin
                    n_mode = MODE_IDENT;
                    n_len  = len_inc;
                    done   = 1'b1;
                end else begin
                    brk = 1'b1;
                end
            end
            MODE_HASH: begin
                if (hex[4]) begin
                    if (r_hcnt < HEX_PACK_MAX) begin
                        n_hacc = {r_hacc[27:0], hex[3:0]};
                    end
                    if (r_hcnt < HEX_COUNT_MAX) begin
                        n_hcnt = r_hcnt + 4'd1;
                    end
                    n_len = len_inc;
                    done  = 1'b1;
                end else begin
                    brk = 1'b1;
                end
            end
            MODE_STRING: begin
                if (i_text_byte == (r_single ? CH_SQUOTE : CH_DQUOTE)) begin
                    brk = 1'b1;
                end else begin
                    if (i_text_byte == CH_BSLASH) begin
                        n_mode = MODE_ESCAPE;
                    end
                    n_len = len_inc;
                end
                done = 1'b1;
            end
            MODE_ESCAPE: begin
                n_mode = MODE_STRING;
                n_len  = len_inc;
                done   = 1'b1;
            end
            default: begin
                n_mode = MODE_IDLE;
            end
        endcase

        if (brk) begin
            cand[0] = make_pending(r_mode, r_start, r_len, r_mag, r_neg, r_ovf,
                                   r_hacc, r_hcnt);
            n_mode  = MODE_IDLE;
        end

        // the byte itself opens a token or is one
        if (!done && !is_space(i_text_byte)) begin
            cand[1].tok.offset = pos_ext[15:0];
            cand[1].tok.size   = 16'd1;
            case (i_text_byte)
                CH_COLON: begin
                    cand[1].valid    = 1'b1;
                    cand[1].tok.kind = KIND_COLON;
                end
                CH_SEMICOLON: begin
                    cand[1].valid    = 1'b1;
                    cand[1].tok.kind = KIND_SEMICOLON;
                end
                CH_LBRACE: begin
                    cand[1].valid    = 1'b1;
                    cand[1].tok.kind = KIND_LBRACE;
                end
                CH_RBRACE: begin
                    cand[1].valid    = 1'b1;
                    cand[1].tok.kind = KIND_RBRACE;
                end
                CH_COMMA: begin
                    cand[1].valid    = 1'b1;
                    cand[1].tok.kind = KIND_COMMA;
                end
                default: begin
                    n_start = pos_ext[15:0];
                    n_len   = 16'd1;
                    n_mag   = '0;
                    n_neg   = 1'b0;
                    n_ovf   = 1'b0;
                    n_hacc  = '0;
                    n_hcnt  = '0;
                    if (i_text_byte == CH_HASH) begin
                        n_mode = MODE_HASH;
                    end else if (i_text_byte == CH_DQUOTE || i_text_byte == CH_SQUOTE) begin
                        n_mode   = MODE_STRING;
                        n_start  = pos_inc[15:0];
                        n_len    = 16'd0;
                        n_single = (i_text_byte == CH_SQUOTE);
                    end else if (is_digit(i_text_byte)) begin
                        n_mode = MODE_NUMBER;
                        n_mag  = 32'(i_text_byte - CH_ZERO);
                    end else if (i_text_byte == CH_MINUS) begin
                        n_mode = MODE_MINUS;
                    end else if (is_alpha(i_text_byte) || i_text_byte == CH_UNDER) begin
                        n_mode = MODE_IDENT;
                    end else begin
                        n_mode           = MODE_IDLE;
                        n_start          = r_start;
                        n_len            = r_len;
                        n_mag            = r_mag;
                        n_neg            = r_neg;
                        n_ovf            = r_ovf;
                        n_hacc           = r_hacc;
                        n_hcnt           = r_hcnt;
                        cand[1].valid    = 1'b1;
                        cand[1].tok.kind = KIND_INVALID;
                    end
                end
            endcase
        end

        if (i_final_byte) begin
            // flush, add the end marker, then start over at offset zero
            cand[2] = make_pending(n_mode, n_start, n_len, n_mag, n_neg, n_ovf,
                                   n_hacc, n_hcnt);
            cand[3].valid      = 1'b1;
            cand[3].tok.kind   = KIND_END;
            cand[3].tok.offset = pos_inc[15:0];
            n_mode   = MODE_IDLE;
            n_pos    = '0;
            n_start  = '0;
            n_len    = '0;
            n_mag    = '0;
            n_neg    = 1'b0;
            n_ovf    = 1'b0;
            n_single = 1'b0;
            n_hacc   = '0;
            n_hcnt   = '0;
        end else begin
            n_pos = (r_pos == POS_W'(MAX_TEXT_BYTES - 1)) ? '0 : r_pos + POS_W'(1);
        end
    end

    // pack the present candidates in order
    always_comb begin
        o_bundle = '0;
        idx      = 2'd0;
        for (int k = 0; k < 4; k++) begin
            if (cand[k].valid) begin
                case (idx)
                    2'd0: o_bundle.tok[0] = cand[k].tok;
                    2'd1: o_bundle.tok[1] = cand[k].tok;
                    2'd2: o_bundle.tok[2] = cand[k].tok;
                    default: ;
                endcase
                idx = idx + 2'd1;
            end
        end
        o_bundle.count = idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_pos    <= '0;
            r_start  <= '0;
            r_len    <= '0;
            r_mag    <= '0;
            r_neg    <= 1'b0;
            r_ovf    <= 1'b0;
            r_single <= 1'b0;
            r_hacc   <= '0;
            r_hcnt   <= '0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_start  <= n_start;
            r_len    <= n_len;
            r_mag    <= n_mag;
            r_neg    <= n_neg;
            r_ovf    <= n_ovf;
            r_single <= n_single;
            r_hacc   <= n_hacc;
            r_hcnt   <= n_hcnt;
        end
    end

endmodule

// File: rtl/stt_result_buf.sv
// result register holding the up to three tokens of one word, drained one per cycle while not stalled
// depends on stt_pkg
module stt_result_buf
    import stt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_bundle i_bundle,
    input  logic    i_stall,
    output logic    o_valid,
    output t_token  o_token,
    output logic    o_run_end,
    output logic    o_ready
);

    t_token [2:0] r_tok;
    logic [1:0]   r_cnt;
    logic [1:0]   r_head;
    logic         pop;

    assign o_valid   = (r_cnt != 2'd0);
    assign o_run_end = (r_cnt == 2'd1);
    assign pop       = o_valid && !i_stall;
    // room for a new word once the last pending token leaves
    assign o_ready   = (r_cnt == 2'd0) || (r_cnt == 2'd1 && pop);

    always_comb begin
        case (r_head)
            2'd0:    o_token = r_tok[0];
            2'd1:    o_token = r_tok[1];
            default: o_token = r_tok[2];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_head <= 2'd0;
        end else if (i_load) begin
            r_cnt  <= i_bundle.count;
            r_head <= 2'd0;
        end else if (pop) begin
            r_cnt  <= r_cnt - 2'd1;
            r_head <= r_head + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tok <= i_bundle.tok;
        end
    end

endmodule

// File: rtl/style_text_tokenizer_unit.sv
// style text tokenizer: one text byte per cycle in, tokens out through a result register
// the first token of a byte shows in the cycle after the byte is accepted, any further
// tokens of that byte follow one per cycle while the output is not stalled
// throughput: one byte per cycle while each byte yields at most one token and the output
// is not stalled; a byte of 2 or 3 tokens holds the input until its last token leaves
// reset: synchronous active-low, returns to offset zero with no open token and no results
module style_text_tokenizer_unit
    import stt_pkg::*;
#(
    parameter int unsigned MAX_TEXT_BYTES = MAX_TEXT_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_text_byte,
    input  logic               i_final_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [3:0]         o_token_kind,
    output logic [15:0]        o_token_offset,
    output logic [15:0]        o_token_size,
    output logic signed [31:0] o_number_value,
    output logic               o_number_saturated,
    output logic [31:0]        o_color_rgba,
    output logic               o_run_end
);

    t_bundle bundle;
    t_token  out_tok;
    logic    buf_ready;
    logic    in_acc;

    assign o_in_stall = !buf_ready;
    assign in_acc     = i_in_valid && buf_ready;

    stt_lexer #(
        .MAX_TEXT_BYTES(MAX_TEXT_BYTES)
    ) u_lexer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_acc),
        .i_text_byte  (i_text_byte),
        .i_final_byte (i_final_byte),
        .o_bundle     (bundle)
    );

    stt_result_buf u_result_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (in_acc),
        .i_bundle  (bundle),
        .i_stall   (i_out_stall),
        .o_valid   (o_out_valid),
        .o_token   (out_tok),
        .o_run_end (o_run_end),
        .o_ready   (buf_ready)
    );

    assign o_token_kind       = out_tok.kind;
    assign o_token_offset     = out_tok.offset;
    assign o_token_size       = out_tok.size;
    assign o_number_value     = out_tok.value;
    assign o_number_saturated = out_tok.sat;
    assign o_color_rgba       = out_tok.color;

`ifndef NO_ASSERTIONS
    a_final_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_final_byte |-> bundle.count != 2'd0)
        else $error("final word produced no result");

    a_final_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_final_byte |=> o_out_valid)
        else $error("no result after final word");

    a_hold_while_draining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_run_end |-> o_in_stall)
        else $error("input taken while several results pending");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_kind == KIND_END |-> o_run_end)
        else $error("end token is not the last result of its word");
`endif

endmodule

// File: tb/sv/stt_token_checker.sv
// token checker for the style text tokenizer: watches both channels, predicts tokens
// from every accepted text word and compares each accepted result word with the oldest one
// depends on stt_pkg for the token struct, kinds, lexer modes and character codes
`timescale 1ns / 1ps
module stt_token_checker
    import stt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [7:0]         i_text_byte,
    input  logic               i_final_byte,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [3:0]         i_token_kind,
    input  logic [15:0]        i_token_offset,
    input  logic [15:0]        i_token_size,
    input  logic signed [31:0] i_number_value,
    input  logic               i_number_saturated,
    input  logic [31:0]        i_color_rgba,
    input  logic               i_run_end,
    output int unsigned        o_fail_count,
    output int unsigned        o_pending,
    output int unsigned        o_checked
);

    typedef struct packed {
        t_token tok;
        logic   last;
    } t_expect;

    t_expect     expected_tokens[$];
    t_token      word_toks[$];
    int unsigned fails = 0;
    int unsigned checked = 0;

    // predicted lexer state
    t_mode       lx_mode;
    logic [15:0] lx_pos;
    logic [15:0] tk_start;
    logic [15:0] tk_len;
    logic [31:0] num_mag;
    logic        num_neg;
    logic        num_ovf;
    logic        quote_single;
    logic [31:0] hex_acc;
    logic [3:0]  hex_cnt;

    function automatic logic chr_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic chr_letter(input logic [7:0] c);
        logic [7:0] lc;
        lc = c | 8'h20;
        return (lc >= 8'h61) && (lc <= 8'h7A);
    endfunction

    function automatic logic chr_blank(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic chr_word(input logic [7:0] c);
        return chr_letter(c) || chr_digit(c) || c == CH_UNDER || c == CH_MINUS;
    endfunction

    // {ok, nibble}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] lc;
        lc = c | 8'h20;
        if (chr_digit(c)) begin
            return {1'b1, c[3:0]};
        end else if ((lc >= 8'h61) && (lc <= 8'h66)) begin
            lc = lc - 8'h57;
            return {1'b1, lc[3:0]};
        end else if (c == CH_LOWER_X) begin
            return 5'b10000;
        end
        return 5'b00000;
    endfunction

    task automatic reset_state();
        lx_mode      = MODE_IDLE;
        lx_pos       = '0;
        tk_start     = '0;
        tk_len       = '0;
        num_mag      = '0;
        num_neg      = 1'b0;
        num_ovf      = 1'b0;
        quote_single = 1'b0;
        hex_acc      = '0;
        hex_cnt      = '0;
    endtask

    task automatic open_token(input t_mode m, input logic [15:0] off, input logic [15:0] len);
        lx_mode  = m;
        tk_start = off;
        tk_len   = len;
        num_mag  = '0;
        num_neg  = 1'b0;
        num_ovf  = 1'b0;
        hex_acc  = '0;
        hex_cnt  = '0;
    endtask

    task automatic grow();
        if (tk_len != SIZE_MAX) tk_len = tk_len + 16'd1;
    endtask

    task automatic add_digit(input logic [7:0] c);
        logic [63:0] m;
        m = {32'd0, num_mag} * 64'd10 + {56'd0, c - CH_ZERO};
        if (m > {32'd0, MAG_MAX}) begin
            m       = {32'd0, MAG_MAX};
            num_ovf = 1'b1;
        end
        num_mag = m[31:0];
    endtask

    task automatic put_mark(input t_kind k, input logic [15:0] off, input logic [15:0] len);
        t_token t;
        t        = '0;
        t.kind   = k;
        t.offset = off;
        t.size   = len;
        word_toks.push_back(t);
    endtask

    // close whatever token is open
    task automatic flush_open();
        t_token t;
        t        = '0;
        t.offset = tk_start;
        t.size   = tk_len;
        case (lx_mode)
            MODE_IDENT, MODE_MINUS: begin
                t.kind = KIND_IDENT;
                word_toks.push_back(t);
            end
            MODE_NUMBER: begin
                t.kind  = KIND_NUMBER;
                t.value = num_neg ? (32'd0 - num_mag) : num_mag;
                t.sat   = num_ovf;
                word_toks.push_back(t);
            end
            MODE_HASH: begin
                t.kind = KIND_HASH;
                if (hex_cnt < HEX_SHORT) t.color = COLOR_WHITE;
                else if (hex_cnt == HEX_RGB) t.color = {hex_acc[23:0], ALPHA_FULL};
                else t.color = hex_acc;
                word_toks.push_back(t);
            end
            MODE_STRING, MODE_ESCAPE: begin
                t.kind = KIND_STRING;
                word_toks.push_back(t);
            end
            default: begin
            end
        endcase
        lx_mode = MODE_IDLE;
    endtask

    task automatic lex_byte(input logic [7:0] c, input logic fin);
        logic [15:0] here;
        logic        taken;
        logic [4:0]  hv;
        here  = lx_pos;
        taken = 1'b0;
        word_toks.delete();
        case (lx_mode)
            MODE_IDENT: begin
                if (chr_word(c)) begin
                    grow();
                    taken = 1'b1;
                end else flush_open();
            end
            MODE_NUMBER: begin
                if (chr_digit(c)) begin
                    add_digit(c);
                    grow();
                    taken = 1'b1;
                end else flush_open();
            end
            MODE_MINUS: begin
                if (chr_digit(c)) begin
                    lx_mode = MODE_NUMBER;
                    num_neg = 1'b1;
                    add_digit(c);
                    grow();
                    taken = 1'b1;
                end else if (chr_word(c)) begin
                    lx_mode = MODE_IDENT;
                    grow();
                    taken = 1'b1;
                end else flush_open();
            end
            MODE_HASH: begin
                hv = hex_digit(c);
                if (hv[4]) begin
                    if (hex_cnt < HEX_PACK_MAX) hex_acc = {hex_acc[27:0], hv[3:0]};
                    if (hex_cnt < HEX_COUNT_MAX) hex_cnt = hex_cnt + 4'd1;
                    grow();
                    taken = 1'b1;
                end else flush_open();
            end
            MODE_STRING: begin
                if (c == (quote_single ? CH_SQUOTE : CH_DQUOTE)) begin
                    flush_open();
                end else begin
                    if (c == CH_BSLASH) lx_mode = MODE_ESCAPE;
                    grow();
                end
                taken = 1'b1;
            end
            MODE_ESCAPE: begin
                lx_mode = MODE_STRING;
                grow();
                taken = 1'b1;
            end
            default: begin
                lx_mode = MODE_IDLE;
            end
        endcase

        if (!taken && !chr_blank(c)) begin
            case (c)
                CH_COLON:     put_mark(KIND_COLON, here, 16'd1);
                CH_SEMICOLON: put_mark(KIND_SEMICOLON, here, 16'd1);
                CH_LBRACE:    put_mark(KIND_LBRACE, here, 16'd1);
                CH_RBRACE:    put_mark(KIND_RBRACE, here, 16'd1);
                CH_COMMA:     put_mark(KIND_COMMA, here, 16'd1);
                CH_HASH:      open_token(MODE_HASH, here, 16'd1);
                CH_DQUOTE, CH_SQUOTE: begin
                    // content starts after the quote
                    open_token(MODE_STRING, here + 16'd1, 16'd0);
                    quote_single = (c == CH_SQUOTE);
                end
                CH_MINUS:     open_token(MODE_MINUS, here, 16'd1);
                default: begin
                    if (chr_digit(c)) begin
                        open_token(MODE_NUMBER, here, 16'd1);
                        add_digit(c);
                    end else if (chr_letter(c) || c == CH_UNDER) begin
                        open_token(MODE_IDENT, here, 16'd1);
                    end else begin
                        put_mark(KIND_INVALID, here, 16'd1);
                    end
                end
            endcase
        end

        if (fin) begin
            flush_open();
            put_mark(KIND_END, here + 16'd1, 16'd0);
            reset_state();
        end else begin
            lx_pos = here + 16'd1;
        end

        foreach (word_toks[k]) begin
            expected_tokens.push_back('{tok: word_toks[k], last: (k == word_toks.size() - 1)});
        end
    endtask

    task automatic check_token();
        t_expect e;
        logic    bad;
        checked++;
        if (expected_tokens.size() == 0) begin
            fails++;
            if (fails <= 10) begin
                $display("unexpected token: kind %0d offset %0d size %0d value %0d sat %0d",
                         i_token_kind, i_token_offset, i_token_size, i_number_value,
                         i_number_saturated);
            end
        end else begin
            e   = expected_tokens.pop_front();
            bad = (i_token_kind !== e.tok.kind) || (i_token_offset !== e.tok.offset) ||
                  (i_token_size !== e.tok.size) || (i_number_value !== e.tok.value) ||
                  (i_number_saturated !== e.tok.sat) || (i_color_rgba !== e.tok.color) ||
                  (i_run_end !== e.last);
            if (bad) begin
                fails++;
                if (fails <= 10) begin
                    $display("token mismatch, expected: kind %0d off %0d size %0d val %0d sat %0d rgba %h end %0d",
                             e.tok.kind, e.tok.offset, e.tok.size, e.tok.value, e.tok.sat,
                             e.tok.color, e.last);
                    $display("                  actual: kind %0d off %0d size %0d val %0d sat %0d rgba %h end %0d",
                             i_token_kind, i_token_offset, i_token_size, i_number_value,
                             i_number_saturated, i_color_rgba, i_run_end);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_state();
            expected_tokens.delete();
            fails   = 0;
            checked = 0;
        end else begin
            // results of earlier words first, then the word taken at this edge
            if (i_out_valid && !i_out_stall) check_token();
            if (i_in_valid && !i_in_stall) lex_byte(i_text_byte, i_final_byte);
        end
        o_fail_count <= fails;
        o_pending    <= expected_tokens.size();
        o_checked    <= checked;
    end

endmodule

// File: tb/sv/style_text_tokenizer_unit_tb.sv
// testbench top for style_text_tokenizer_unit: builds style texts, drives them word by word
// with random gaps and output stalls, and reports the verdict from stt_token_checker
// depends on stt_pkg, style_text_tokenizer_unit and stt_token_checker
`timescale 1ns / 1ps
module style_text_tokenizer_unit_tb
    import stt_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT  = 50000;
    localparam int unsigned RANDOM_BYTES = 20;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic [7:0]         i_text_byte = 8'h00;
    logic               i_final_byte = 1'b0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [3:0]         o_token_kind;
    logic [15:0]        o_token_offset;
    logic [15:0]        o_token_size;
    logic signed [31:0] o_number_value;
    logic               o_number_saturated;
    logic [31:0]        o_color_rgba;
    logic               o_run_end;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;
    int unsigned send_pct = 0;
    int unsigned recv_pct = 0;
    int unsigned bytes_sent = 0;
    int unsigned texts_sent = 0;
    int unsigned cycles = 0;
    logic [7:0]  text_buf[$];

    style_text_tokenizer_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_text_byte        (i_text_byte),
        .i_final_byte       (i_final_byte),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_token_kind       (o_token_kind),
        .o_token_offset     (o_token_offset),
        .o_token_size       (o_token_size),
        .o_number_value     (o_number_value),
        .o_number_saturated (o_number_saturated),
        .o_color_rgba       (o_color_rgba),
        .o_run_end          (o_run_end)
    );

    stt_token_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_text_byte        (i_text_byte),
        .i_final_byte       (i_final_byte),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_token_kind       (o_token_kind),
        .i_token_offset     (o_token_offset),
        .i_token_size       (o_token_size),
        .i_number_value     (o_number_value),
        .i_number_saturated (o_number_saturated),
        .i_color_rgba       (o_color_rgba),
        .i_run_end          (o_run_end),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_checked          (checked)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_pct);
    end

    function automatic logic [7:0] rand_letter();
        logic [7:0] c;
        c = 8'h61 + 8'($urandom_range(25));
        if ($urandom_range(1) == 1) c = c - 8'h20;
        return c;
    endfunction

    function automatic logic [7:0] rand_hex();
        case ($urandom_range(3))
            0: return 8'h30 + 8'($urandom_range(9));
            1: return 8'h61 + 8'($urandom_range(5));
            2: return 8'h41 + 8'($urandom_range(5));
            default: return CH_LOWER_X;
        endcase
    endfunction

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endtask

    // one lexical piece with random content, now and then plain noise
    task automatic add_fragment();
        int unsigned pick;
        int unsigned n;
        logic [7:0]  q;
        pick = $urandom_range(99);
        if (pick < 20) begin
            text_buf.push_back(($urandom_range(9) == 0) ? CH_UNDER : rand_letter());
            n = $urandom_range(6);
            repeat (n) begin
                case ($urandom_range(5))
                    0: text_buf.push_back(8'h30 + 8'($urandom_range(9)));
                    1: text_buf.push_back(CH_UNDER);
                    2: text_buf.push_back(CH_MINUS);
                    default: text_buf.push_back(rand_letter());
                endcase
            end
        end else if (pick < 38) begin
            if ($urandom_range(9) < 3) text_buf.push_back(CH_MINUS);
            if ($urandom_range(9) == 0) begin
                add_str(($urandom_range(1) == 1) ? "2147483647" : "2147483648");
            end else begin
                n = ($urandom_range(6) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 4);
                repeat (n) text_buf.push_back(8'h30 + 8'($urandom_range(9)));
            end
        end else if (pick < 52) begin
            text_buf.push_back(CH_HASH);
            n = $urandom_range(10);
            repeat (n) text_buf.push_back(rand_hex());
        end else if (pick < 64) begin
            q = ($urandom_range(1) == 1) ? CH_SQUOTE : CH_DQUOTE;
            text_buf.push_back(q);
            n = $urandom_range(6);
            repeat (n) begin
                if ($urandom_range(6) == 0) begin
                    text_buf.push_back(CH_BSLASH);
                    text_buf.push_back(($urandom_range(1) == 1) ? q : 8'($urandom_range(32, 126)));
                end else begin
                    text_buf.push_back(8'($urandom_range(32, 126)));
                end
            end
            if ($urandom_range(99) < 85) text_buf.push_back(q);
        end else if (pick < 76) begin
            case ($urandom_range(4))
                0: text_buf.push_back(CH_COLON);
                1: text_buf.push_back(CH_SEMICOLON);
                2: text_buf.push_back(CH_LBRACE);
                3: text_buf.push_back(CH_RBRACE);
                default: text_buf.push_back(CH_COMMA);
            endcase
        end else if (pick < 86) begin
            text_buf.push_back(($urandom_range(1) == 1) ? 8'h20 : 8'($urandom_range(9, 13)));
        end else if (pick < 91) begin
            text_buf.push_back(CH_MINUS);
        end else begin
            text_buf.push_back(8'($urandom_range(255)));
        end
        if ($urandom_range(9) < 4) text_buf.push_back(8'h20);
    endtask

    // present one word and hold it until it is taken
    task automatic send_word(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_text_byte  <= b;
        i_final_byte <= fin;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_text();
        foreach (text_buf[i]) begin
            send_word(text_buf[i], i == text_buf.size() - 1);
            bytes_sent++;
        end
        texts_sent++;
        text_buf.delete();
    endtask

    task automatic random_texts(input int unsigned n);
        int unsigned start;
        int unsigned target;
        start = bytes_sent;
        while (bytes_sent - start < n) begin
            target = $urandom_range(2, 18);
            while (text_buf.size() < target) add_fragment();
            send_text();
        end
    endtask

    // hold the sender off until every predicted token has come out
    task automatic drain_tokens();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_pct = 19;
        recv_pct = 73;
        // lone minus as the final byte
        add_str("-");
        send_text();
        // six hex chars with x, marks, extreme bytes, unterminated string with escaped quote
        add_str("{#fF0x8A;");
        text_buf.push_back(8'hFF);
        text_buf.push_back(8'h00);
        add_str(":\"a\\\"");
        send_text();
        // minus into identifier, comma, single quoted string
        add_str("-q,'b'}");
        send_text();
        add_str("-5");
        send_text();
        random_texts(RANDOM_BYTES);
        drain_tokens();

        send_pct = 73;
        recv_pct = 19;
        random_texts(RANDOM_BYTES);
        drain_tokens();

        send_pct = 0;
        recv_pct = 0;
        random_texts(RANDOM_BYTES);
        drain_tokens();
        repeat (20) @(posedge i_clk);

        $display("sent %0d bytes in %0d texts under three gap/stall mixes, edge cases first",
                 bytes_sent, texts_sent);
        $display("checked %0d tokens, %0d failures", checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: style_text_tokenizer_unit.f
rtl/stt_pkg.sv
rtl/stt_lexer.sv
rtl/stt_result_buf.sv
rtl/style_text_tokenizer_unit.sv
tb/sv/stt_token_checker.sv
tb/sv/style_text_tokenizer_unit_tb.sv
